// ===== rtl/bpmd_pkg.sv =====
// ----------------------------------------------------------------------------
// bpmd_pkg
// Shared types and constants for the button press motor direction control core.
// ----------------------------------------------------------------------------
package bpmd_pkg;

	// default width of the press and dead time counters
	localparam int unsigned COUNT_WIDTH_DEF = 16;

	// configuration register widths
	localparam int unsigned LONG_W = 16;
	localparam int unsigned DEB_W  = 8;
	localparam int unsigned DEAD_W = 16;
	localparam int unsigned CFG_W  = 16;
	localparam int unsigned CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEAD_TIME  = 2'd2;

	// configuration reset values
	localparam logic [LONG_W-1:0] LONG_PRESS_RST = 16'd1000;
	localparam logic [DEB_W-1:0]  DEBOUNCE_RST   = 8'd10;
	localparam logic [DEAD_W-1:0] DEAD_TIME_RST  = 16'd100;

	// duty handling
	localparam int unsigned DUTY_W = 7;
	localparam logic [DUTY_W-1:0] DUTY_RST  = 7'd55;
	localparam logic [DUTY_W-1:0] DUTY_BASE = 7'd60;
	localparam logic [DUTY_W-1:0] DUTY_STEP = 7'd5;
	localparam logic [7:0] CHAR_FIRST = 8'h31;
	localparam logic [7:0] CHAR_LAST  = 8'h39;

	// request kinds
	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_UART = 1'b1;

	typedef enum logic [2:0] {
		KP_IDLE,
		KP_PRESSED,
		KP_PRESS_CHECK,
		KP_WAIT_RELEASE,
		KP_RELEASE_CHECK
	} key_phase_t;

	// encoding matches the drive output for the running phases
	typedef enum logic [1:0] {
		MP_STOP    = 2'd0,
		MP_FORWARD = 2'd1,
		MP_REVERSE = 2'd2,
		MP_DEAD    = 2'd3
	} motor_phase_t;

	typedef struct packed {
		logic       action;
		logic       key_level;
		logic [7:0] rx_char;
	} req_t;

	typedef struct packed {
		logic [1:0]        drive;
		logic [DUTY_W-1:0] duty_percent;
		logic              short_event;
		logic              long_event;
	} rsp_t;

	typedef struct packed {
		logic [LONG_W-1:0] long_press_ticks;
		logic [DEB_W-1:0]  debounce_ticks;
		logic [DEAD_W-1:0] dead_time_ticks;
	} cfg_t;

	typedef struct packed {
		logic short_ev;
		logic long_ev;
	} key_evt_t;

	typedef struct packed {
		logic dead;
	} motor_stat_t;

endpackage

// ===== rtl/bpmd_key.sv =====
// ----------------------------------------------------------------------------
// bpmd_key
// Key press classifier: tracks a press over ticks and reports short and long
// presses, with a debounce re-check on each apparent release if debounce is set.
// ----------------------------------------------------------------------------
module bpmd_key #(
	parameter int unsigned COUNT_WIDTH = bpmd_pkg::COUNT_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tick_en,
	input  logic               key_level,
	input  bpmd_pkg::cfg_t     cfg,
	output bpmd_pkg::key_evt_t evt
);
	import bpmd_pkg::*;

	localparam int unsigned CMP_W = (COUNT_WIDTH > LONG_W) ? COUNT_WIDTH : LONG_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	key_phase_t phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] press_q, press_d, press_inc;
	logic [DEB_W-1:0] deb_q, deb_d;
	logic press_long, deb_last;

	// saturating press count and long press test
	assign press_inc  = (press_q == CNT_MAX) ? press_q : press_q + 1'b1;
	assign press_long = (CMP_W'(press_inc) >= CMP_W'(cfg.long_press_ticks)) ||
	                    (press_inc == CNT_MAX);
	assign deb_last   = (deb_q <= DEB_W'(1));

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (tick_en) begin
			unique case (phase_q)
				KP_IDLE: begin
					if (key_level) phase_d = KP_PRESSED;
				end
				KP_PRESSED: begin
					if (press_long) begin
						phase_d = KP_WAIT_RELEASE;
					end else if (!key_level) begin
						phase_d = (cfg.debounce_ticks == '0) ? KP_IDLE : KP_PRESS_CHECK;
					end
				end
				KP_PRESS_CHECK: begin
					if (deb_last) phase_d = key_level ? KP_PRESSED : KP_IDLE;
				end
				KP_WAIT_RELEASE: begin
					if (!key_level) begin
						phase_d = (cfg.debounce_ticks == '0) ? KP_IDLE : KP_RELEASE_CHECK;
					end
				end
				KP_RELEASE_CHECK: begin
					if (deb_last) phase_d = key_level ? KP_WAIT_RELEASE : KP_IDLE;
				end
				default: phase_d = KP_IDLE;
			endcase
		end
	end

	// counters and events
	always_comb begin
		press_d      = press_q;
		deb_d        = deb_q;
		evt.short_ev = 1'b0;
		evt.long_ev  = 1'b0;
		if (tick_en) begin
			unique case (phase_q)
				KP_IDLE: begin
					if (key_level) press_d = '0;
				end
				KP_PRESSED: begin
					press_d = press_inc;
					if (press_long) begin
						evt.long_ev = 1'b1;
					end else if (!key_level) begin
						if (cfg.debounce_ticks == '0) evt.short_ev = 1'b1;
						else deb_d = cfg.debounce_ticks;
					end
				end
				KP_PRESS_CHECK: begin
					press_d = press_inc;
					if (deb_last) begin
						deb_d        = '0;
						evt.short_ev = !key_level;
					end else begin
						deb_d = deb_q - 1'b1;
					end
				end
				KP_WAIT_RELEASE: begin
					if (!key_level && cfg.debounce_ticks != '0) deb_d = cfg.debounce_ticks;
				end
				KP_RELEASE_CHECK: begin
					deb_d = deb_last ? '0 : deb_q - 1'b1;
				end
				default: begin
					deb_d = '0;
				end
			endcase
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= KP_IDLE;
			press_q <= '0;
			deb_q   <= '0;
		end else begin
			phase_q <= phase_d;
			press_q <= press_d;
			deb_q   <= deb_d;
		end
	end

	// a press ends as short or long, never both
	a_evt_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(evt.short_ev && evt.long_ev))
		else $error("short and long press in one request");

	// events come only from an advancing tick
	a_evt_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(evt.short_ev || evt.long_ev) |-> tick_en)
		else $error("key event without a tick");

	// the debounce counter is idle in the idle and wait-release phases
	a_deb_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == KP_IDLE || phase_q == KP_WAIT_RELEASE) |-> (deb_q == '0))
		else $error("debounce counter running outside a check");

endmodule

// ===== rtl/bpmd_motor.sv =====
// ----------------------------------------------------------------------------
// bpmd_motor
// Motor direction sequencer with reversal dead time, and duty setting from
// received digit characters.
// ----------------------------------------------------------------------------
module bpmd_motor #(
	parameter int unsigned COUNT_WIDTH = bpmd_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_en,
	input  bpmd_pkg::req_t                item,
	input  bpmd_pkg::key_evt_t            evt,
	input  bpmd_pkg::cfg_t                cfg,
	output bpmd_pkg::motor_stat_t         stat,
	output logic [1:0]                    drive,
	output logic [bpmd_pkg::DUTY_W-1:0]   duty_percent
);
	import bpmd_pkg::*;

	localparam int unsigned DMW = (COUNT_WIDTH > DEAD_W) ? COUNT_WIDTH : DEAD_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	motor_phase_t phase_q, phase_d, pend_q, pend_d, target;
	logic [COUNT_WIDTH-1:0] dead_q, dead_d, dead_load;
	logic [DUTY_W-1:0] duty_q, duty_d;
	logic is_tick, is_digit, dead_last, step;
	logic [7:0] char_off;

	assign is_tick   = item_en && (item.action == ACT_TICK);
	assign char_off  = item.rx_char - CHAR_FIRST;
	assign is_digit  = (item.rx_char >= CHAR_FIRST) && (item.rx_char <= CHAR_LAST);
	assign dead_last = (dead_q <= COUNT_WIDTH'(1));
	assign step      = is_tick && (phase_q != MP_DEAD) && !evt.long_ev && evt.short_ev;
	assign target    = (phase_q == MP_FORWARD) ? MP_REVERSE : MP_FORWARD;

	// dead time saturated to the counter range
	assign dead_load = (DMW'(cfg.dead_time_ticks) > DMW'(CNT_MAX)) ? CNT_MAX :
	                   COUNT_WIDTH'(cfg.dead_time_ticks);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (is_tick) begin
			if (phase_q == MP_DEAD) begin
				if (dead_last) phase_d = pend_q;
			end else if (evt.long_ev) begin
				phase_d = MP_STOP;
			end else if (step) begin
				if (phase_q == MP_STOP) phase_d = MP_FORWARD;
				else if (cfg.dead_time_ticks == '0) phase_d = target;
				else phase_d = MP_DEAD;
			end
		end
	end

	// dead counter, pending direction, duty and outputs
	always_comb begin
		dead_d = dead_q;
		pend_d = pend_q;
		duty_d = duty_q;
		if (item_en && item.action == ACT_UART && is_digit) begin
			duty_d = DUTY_W'(DUTY_W'(char_off[3:0]) * DUTY_STEP + DUTY_BASE);
		end
		if (is_tick && phase_q == MP_DEAD) begin
			dead_d = dead_last ? '0 : dead_q - 1'b1;
		end else if (step && phase_q != MP_STOP && cfg.dead_time_ticks != '0) begin
			dead_d = dead_load;
			pend_d = target;
		end
		drive        = (phase_d == MP_DEAD) ? 2'(MP_STOP) : 2'(phase_d);
		duty_percent = duty_d;
		stat.dead    = (phase_q == MP_DEAD);
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= MP_STOP;
			pend_q  <= MP_STOP;
			dead_q  <= '0;
			duty_q  <= DUTY_RST;
		end else begin
			phase_q <= phase_d;
			pend_q  <= pend_d;
			dead_q  <= dead_d;
			duty_q  <= duty_d;
		end
	end

	// dead counter runs only during a reversal pause
	a_dead_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != MP_DEAD) |-> (dead_q == '0))
		else $error("dead counter set outside dead time");

	// a character never moves the motor
	a_uart_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(item_en && item.action == ACT_UART) |=> (phase_q == $past(phase_q)))
		else $error("character request changed motor phase");

	// the pending direction is always a running direction during dead time
	a_pend_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == MP_DEAD) |-> (pend_q == MP_FORWARD || pend_q == MP_REVERSE))
		else $error("dead time without a target direction");

endmodule

// ===== rtl/button_press_motor_direction_control_core.sv =====
// ----------------------------------------------------------------------------
// button_press_motor_direction_control_core
// Takes one request per clock: a tick carrying the button level or a received
// character. Each request gives exactly one result, held in the input and then
// the result register; the whole state update of the key classifier and the
// motor sequencer is one pass of logic between them, so the sustained rate is
// one request per cycle while the result side keeps up. A long press stops the
// motor; a short press steps stop, forward, reverse, forward, with any nonzero
// dead time held at stop before each reversal, ticks only counting it down.
// Digits 1 to 9 set the duty from 60 to 100 percent. Configuration is written
// through a plain write port; the user must write only while idle (unenforced).
// ----------------------------------------------------------------------------
module button_press_motor_direction_control_core #(
	parameter int unsigned COUNT_WIDTH = bpmd_pkg::COUNT_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [bpmd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bpmd_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  bpmd_pkg::req_t                   req,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output bpmd_pkg::rsp_t                   rsp
);
	import bpmd_pkg::*;

	cfg_t cfg_q;
	req_t item_s1;
	logic item_valid_s1, adv, tick_en;
	key_evt_t evt;
	motor_stat_t mstat;
	logic [1:0] drive;
	logic [DUTY_W-1:0] duty;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ticks <= LONG_PRESS_RST;
			cfg_q.debounce_ticks   <= DEBOUNCE_RST;
			cfg_q.dead_time_ticks  <= DEAD_TIME_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_LONG_PRESS: cfg_q.long_press_ticks <= cfg_data[LONG_W-1:0];
				CFG_DEBOUNCE:   cfg_q.debounce_ticks   <= cfg_data[DEB_W-1:0];
				CFG_DEAD_TIME:  cfg_q.dead_time_ticks  <= cfg_data[DEAD_W-1:0];
				default:        ;
			endcase
		end
	end

	// handshake: the input stage moves on whenever the result register frees
	assign adv       = item_valid_s1 && (!rsp_valid || !rsp_stall);
	assign req_stall = item_valid_s1 && rsp_valid && rsp_stall;
	assign tick_en   = adv && (item_s1.action == ACT_TICK) && !mstat.dead;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			item_valid_s1 <= 1'b1;
		end else if (adv) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) item_s1 <= req;
	end

	bpmd_key #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_key (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick_en   (tick_en),
		.key_level (item_s1.key_level),
		.cfg       (cfg_q),
		.evt       (evt)
	);

	bpmd_motor #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_motor (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_en      (adv),
		.item         (item_s1),
		.evt          (evt),
		.cfg          (cfg_q),
		.stat         (mstat),
		.drive        (drive),
		.duty_percent (duty)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp.drive        <= drive;
			rsp.duty_percent <= duty;
			rsp.short_event  <= evt.short_ev;
			rsp.long_event   <= evt.long_ev;
		end
	end

	// a held request waits while the result side is blocked
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid_s1 && rsp_valid && rsp_stall) |=> item_valid_s1)
		else $error("request dropped while result stalled");

	// drive never shows the dead time code
	a_drive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.drive != 2'(MP_DEAD)))
		else $error("invalid drive code");

	// duty stays within its reset value and full scale
	a_duty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.duty_percent >= DUTY_RST && rsp.duty_percent <= 7'd100))
		else $error("duty out of range");

endmodule

// ===== sim/bpmd_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bpmd_result_checker
// Watches the configuration, request and result ports of the motor direction
// core. Keeps its own copy of the key classifier, the motor sequencer and the
// duty setting, works out the result of every accepted request and compares
// each accepted result, field by field and in order, with the oldest one.
// ----------------------------------------------------------------------------
module bpmd_result_checker #(
	parameter int unsigned COUNT_WIDTH = bpmd_pkg::COUNT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [bpmd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bpmd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           req_valid,
	input  logic                           req_stall,
	input  bpmd_pkg::req_t                 req,
	input  logic                           rsp_valid,
	input  logic                           rsp_stall,
	input  bpmd_pkg::rsp_t                 rsp,
	output int                             error_count,
	output int                             outstanding
);
	import bpmd_pkg::*;

	localparam longint unsigned CNT_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;

	// mirrored configuration
	logic [LONG_W-1:0] long_cfg;
	logic [DEB_W-1:0]  deb_cfg;
	logic [DEAD_W-1:0] dead_cfg;

	// mirrored state
	key_phase_t             key_st;
	logic [COUNT_WIDTH-1:0] press_cnt;
	logic [DEB_W-1:0]       deb_cnt;
	motor_phase_t           motor_st;
	logic [COUNT_WIDTH-1:0] dead_cnt;
	motor_phase_t           next_dir;
	logic [DUTY_W-1:0]      duty;

	rsp_t pending_motor_outputs[$];
	rsp_t predicted;
	rsp_t oldest;

	// hold the drive at stop before a direction change
	task automatic begin_reversal(input motor_phase_t target);
		if (dead_cfg == '0) begin
			motor_st = target;
		end else begin
			motor_st = MP_DEAD;
			next_dir = target;
			if (64'(dead_cfg) > CNT_MAX) begin
				dead_cnt = '1;
			end else begin
				dead_cnt = COUNT_WIDTH'(dead_cfg);
			end
		end
	endtask

	// one request through the controller
	task automatic step_motor_controller(input req_t r, output rsp_t o);
		logic sh;
		logic lg;
		sh = 1'b0;
		lg = 1'b0;
		if (r.action == ACT_UART) begin
			// digits set the duty, anything else is dropped
			if (r.rx_char >= CHAR_FIRST && r.rx_char <= CHAR_LAST) begin
				duty = DUTY_BASE + DUTY_STEP * DUTY_W'(r.rx_char - CHAR_FIRST);
			end
		end else if (motor_st == MP_DEAD) begin
			// ticks only count the dead time down
			if (dead_cnt <= 1) begin
				dead_cnt = '0;
				motor_st = next_dir;
			end else begin
				dead_cnt = dead_cnt - 1'b1;
			end
		end else begin
			case (key_st)
				KP_IDLE: begin
					if (r.key_level) begin
						key_st = KP_PRESSED;
						press_cnt = '0;
					end
				end
				KP_PRESSED: begin
					if (press_cnt != '1) press_cnt = press_cnt + 1'b1;
					if (press_cnt >= long_cfg || press_cnt == '1) begin
						lg = 1'b1;
						key_st = KP_WAIT_RELEASE;
					end else if (!r.key_level) begin
						if (deb_cfg == '0) begin
							sh = 1'b1;
							key_st = KP_IDLE;
						end else begin
							key_st = KP_PRESS_CHECK;
							deb_cnt = deb_cfg;
						end
					end
				end
				KP_PRESS_CHECK: begin
					if (press_cnt != '1) press_cnt = press_cnt + 1'b1;
					if (deb_cnt <= 1) begin
						deb_cnt = '0;
						if (!r.key_level) begin
							sh = 1'b1;
							key_st = KP_IDLE;
						end else begin
							key_st = KP_PRESSED;
						end
					end else begin
						deb_cnt = deb_cnt - 1'b1;
					end
				end
				KP_WAIT_RELEASE: begin
					if (!r.key_level) begin
						if (deb_cfg == '0) begin
							key_st = KP_IDLE;
						end else begin
							key_st = KP_RELEASE_CHECK;
							deb_cnt = deb_cfg;
						end
					end
				end
				default: begin
					// release re-check after a long press
					if (deb_cnt <= 1) begin
						deb_cnt = '0;
						key_st = r.key_level ? KP_WAIT_RELEASE : KP_IDLE;
					end else begin
						deb_cnt = deb_cnt - 1'b1;
					end
				end
			endcase
			// motor sequencing on key events
			if (lg) begin
				motor_st = MP_STOP;
			end else if (sh) begin
				case (motor_st)
					MP_STOP:    motor_st = MP_FORWARD;
					MP_FORWARD: begin_reversal(MP_REVERSE);
					default:    begin_reversal(MP_FORWARD);
				endcase
			end
		end
		o.drive = (motor_st == MP_DEAD) ? MP_STOP : motor_st;
		o.duty_percent = duty;
		o.short_event = sh;
		o.long_event = lg;
	endtask

	// mirror writes, compare results, predict requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_cfg = LONG_PRESS_RST;
			deb_cfg = DEBOUNCE_RST;
			dead_cfg = DEAD_TIME_RST;
			key_st = KP_IDLE;
			press_cnt = '0;
			deb_cnt = '0;
			motor_st = MP_STOP;
			dead_cnt = '0;
			next_dir = MP_STOP;
			duty = DUTY_RST;
			pending_motor_outputs.delete();
			error_count = 0;
			outstanding = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_LONG_PRESS: long_cfg = cfg_data[LONG_W-1:0];
					CFG_DEBOUNCE:   deb_cfg = cfg_data[DEB_W-1:0];
					CFG_DEAD_TIME:  dead_cfg = cfg_data[DEAD_W-1:0];
					default: ;
				endcase
			end
			if (rsp_valid && !rsp_stall) begin
				if (pending_motor_outputs.size() == 0) begin
					$error("result with no request waiting: %h", rsp);
					error_count++;
				end else begin
					oldest = pending_motor_outputs.pop_front();
					if (rsp.drive !== oldest.drive) begin
						$error("drive: expected %0d, got %0d", oldest.drive, rsp.drive);
						error_count++;
					end
					if (rsp.duty_percent !== oldest.duty_percent) begin
						$error("duty_percent: expected %0d, got %0d",
							oldest.duty_percent, rsp.duty_percent);
						error_count++;
					end
					if (rsp.short_event !== oldest.short_event) begin
						$error("short_event: expected %0d, got %0d",
							oldest.short_event, rsp.short_event);
						error_count++;
					end
					if (rsp.long_event !== oldest.long_event) begin
						$error("long_event: expected %0d, got %0d",
							oldest.long_event, rsp.long_event);
						error_count++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				step_motor_controller(req, predicted);
				pending_motor_outputs.push_back(predicted);
			end
			outstanding = pending_motor_outputs.size();
		end
	end

endmodule

// ===== sim/button_press_motor_direction_control_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_press_motor_direction_control_core_tb
// Drives ticks and characters into the motor direction core through several
// configurations, the extremes among them: directed characters and presses
// first, then press and release sequences with random lengths, bounces and
// interleaved characters, with random gaps on the request side and random
// stalls on the result side. The checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module button_press_motor_direction_control_core_tb;
	import bpmd_pkg::*;

	localparam longint CYCLE_LIMIT = 64'd10_000_000;

	// result side stall patterns
	localparam int STALL_NONE  = 0;
	localparam int STALL_LIGHT = 1;
	localparam int STALL_HEAVY = 2;
	localparam int STALL_FULL  = 3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp;
	int                   error_count;
	int                   outstanding;

	longint      cycle_count = 0;
	int          stall_left = 0;
	int          stall_mode = STALL_NONE;
	int          burst_left = 0;
	int          sent_items = 0;
	int unsigned cur_long = LONG_PRESS_RST;
	int unsigned cur_deb = DEBOUNCE_RST;

	button_press_motor_direction_control_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	bpmd_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.error_count (error_count),
		.outstanding (outstanding)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("button_press_motor_direction_control_core_tb: errors");
			$finish;
		end
	end

	// result side stall pattern
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(STALL_NONE, STALL_FULL);
			stall_left = (stall_mode == STALL_FULL) ? $urandom_range(1, 20)
				: $urandom_range(10, 80);
		end
		stall_left--;
		case (stall_mode)
			STALL_NONE:  rsp_stall <= 1'b0;
			STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 6);
			default:     rsp_stall <= 1'b1;
		endcase
	end

	// one request, sent in bursts with gaps between them
	task automatic send_request(input req_t item);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
		burst_left--;
		sent_items++;
	endtask

	task automatic send_char(input logic [7:0] c);
		req_t item;
		item.action = ACT_UART;
		item.key_level = 1'($urandom);
		item.rx_char = c;
		send_request(item);
	endtask

	// digits half the time, otherwise any byte
	task automatic send_random_char();
		if ($urandom_range(0, 1) == 0) begin
			send_char(8'($urandom_range(CHAR_FIRST, CHAR_LAST)));
		end else begin
			send_char(8'($urandom));
		end
	endtask

	// a tick, now and then preceded by a character
	task automatic send_tick(input logic level);
		req_t item;
		if ($urandom_range(0, 11) == 0) send_random_char();
		item.action = ACT_TICK;
		item.key_level = level;
		item.rx_char = 8'($urandom);
		send_request(item);
	endtask

	// write all registers once the core has nothing in flight
	task automatic configure(input int unsigned long_v, deb_v, dead_v);
		req_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_LONG_PRESS;
		cfg_data <= LONG_W'(long_v);
		@(negedge clk);
		cfg_index <= CFG_DEBOUNCE;
		cfg_data <= {8'($urandom), DEB_W'(deb_v)};
		@(negedge clk);
		cfg_index <= CFG_DEAD_TIME;
		cfg_data <= DEAD_W'(dead_v);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
		cur_long = long_v;
		cur_deb = deb_v;
	endtask

	// press of random length, then a release with an optional bounce
	task automatic press_sequence();
		int unsigned hold;
		int unsigned rel;
		int unsigned reach;
		int bounce_at;
		reach = (cur_long > 100) ? 12 : cur_long;
		case ($urandom_range(0, 9))
			0, 1:    hold = reach + $urandom_range(0, 3);
			2, 3:    hold = $urandom_range((reach > 1) ? reach - 1 : 1, reach + 1);
			default: hold = $urandom_range(1, (reach > 12) ? 12 : ((reach > 1) ? reach : 1));
		endcase
		for (int unsigned n = 0; n < hold; n++) begin
			send_tick(!(n > 0 && $urandom_range(0, 19) == 0));
		end
		rel = cur_deb + $urandom_range(1, 4);
		bounce_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, rel - 1) : -1;
		for (int n = 0; n < rel; n++) begin
			send_tick(n == bounce_at);
		end
		repeat ($urandom_range(0, 3)) send_tick(1'b0);
	endtask

	// random ticks and characters
	task automatic noise_item();
		if ($urandom_range(0, 3) == 0) begin
			send_random_char();
		end else begin
			send_tick(1'($urandom));
		end
	endtask

	task automatic run_phase(input int items);
		int first;
		first = sent_items;
		while (sent_items - first < items) begin
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 10)) noise_item();
			end else begin
				press_sequence();
			end
		end
	endtask

	// stimulus and verdict
	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// characters under reset settings: both duty ends and ignored bytes
		send_char(CHAR_FIRST);
		send_char(CHAR_LAST);
		send_char(8'h30);
		send_char(8'h3A);
		send_char(8'hFF);
		send_char(8'h00);

		// directed presses with short settings
		configure(3, 1, 2);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		send_char(8'h35);
		send_tick(1'b0);
		send_tick(1'b0);
		repeat (4) send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);

		// random phases over several settings
		configure(LONG_PRESS_RST, DEBOUNCE_RST, DEAD_TIME_RST);
		run_phase(100);
		configure(5, 2, 3);
		run_phase(100);
		configure(1, 0, 0);
		run_phase(80);
		configure(0, 0, 1);
		run_phase(60);
		configure(0, 1, 0);
		run_phase(60);
		configure(12, 255, 4);
		run_phase(150);
		configure(2, 1, 7);
		run_phase(100);
		configure(7, 3, 2);
		run_phase(100);

		// widest settings: two short presses, the second into the longest dead time
		configure(65535, 255, 65535);
		repeat (2) begin
			send_tick(1'b1);
			repeat (260) send_tick(1'b0);
		end
		repeat (20) noise_item();

		req_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		if (error_count == 0 && outstanding == 0) begin
			$display("button_press_motor_direction_control_core_tb: clean");
		end else begin
			$display("button_press_motor_direction_control_core_tb: errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/bpmd_pkg.sv
rtl/bpmd_key.sv
rtl/bpmd_motor.sv
rtl/button_press_motor_direction_control_core.sv
sim/bpmd_result_checker.sv
sim/button_press_motor_direction_control_core_tb.sv
